FILE: rtl/pds_pkg.sv
package pds_pkg;

    localparam int NUMBER_WIDTH = 20;
    localparam int SUM_WIDTH    = 23;

    // running divisor sum; never exceeds 8x the number
    localparam int SIG_W   = (NUMBER_WIDTH + 3 > SUM_WIDTH) ? NUMBER_WIDTH + 3 : SUM_WIDTH;
    localparam int ALU_W   = SIG_W + 1;
    localparam int D_W     = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int DSQ_W   = NUMBER_WIDTH + 1;
    localparam int DINC_W  = D_W + 2;
    localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);
    localparam int IN_TDATA_W  = ((NUMBER_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_WIDTH + 7) / 8) * 8;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWO,
        ST_CHECK,
        ST_DIV,
        ST_DIVEND,
        ST_MUL,
        ST_NEXT,
        ST_SUB
    } state_t;

    typedef enum logic [1:0] {
        MUL_TERM,
        MUL_SIGMA,
        MUL_REST
    } mul_kind_t;

endpackage

FILE: rtl/proper_divisor_sum.sv
// Work: a trial division for each odd divisor up to sqrt of the unfactored rest, plus
// shift-add multiplications for the factors found. The restoring divider makes one
// quotient bit a cycle.
// Throughput: one number at a time; s_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next number is taken.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and clears m_tvalid.
module proper_divisor_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pds_pkg::IN_TDATA_W-1:0]      s_tdata,  // [19:0] number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pds_pkg::OUT_TDATA_W-1:0]     m_tdata   // [22:0] proper_sum
);

    pds_pkg::state_t                      state_reg, state_next;
    pds_pkg::mul_kind_t                   mkind_reg, mkind_next;
    logic [pds_pkg::NUMBER_WIDTH-1:0]     n_reg, n_next;
    logic [pds_pkg::NUMBER_WIDTH-1:0]     rest_reg, rest_next;
    logic [pds_pkg::SIG_W-1:0]            sigma_reg, sigma_next;
    logic [pds_pkg::SIG_W-1:0]            term_reg, term_next;
    logic [pds_pkg::D_W-1:0]              d_reg, d_next;
    logic [pds_pkg::DSQ_W-1:0]            dsq_reg, dsq_next;
    logic [pds_pkg::DINC_W-1:0]           dinc_reg, dinc_next;
    logic [pds_pkg::NUMBER_WIDTH-1:0]     quo_reg, quo_next;
    logic [pds_pkg::D_W-1:0]              rem_reg, rem_next;
    logic [pds_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [pds_pkg::SIG_W-1:0]            acc_reg, acc_next;
    logic [pds_pkg::SIG_W-1:0]            x_reg, x_next;
    logic [pds_pkg::SIG_W-1:0]            y_reg, y_next;
    logic [pds_pkg::SUM_WIDTH-1:0]        sum_reg, sum_next;
    logic                                 m_tvalid_reg, m_tvalid_next;

    logic [pds_pkg::NUMBER_WIDTH-1:0]     num_in;
    logic [pds_pkg::D_W:0]                rem_shift;
    logic [pds_pkg::ALU_W-1:0]            alu_a, alu_b, alu_res;
    logic                                 alu_sub;
    logic                                 borrow;
    logic [pds_pkg::SIG_W-1:0]            diff;
    logic                                 out_free;

    assign num_in    = s_tdata[pds_pkg::NUMBER_WIDTH-1:0];
    assign rem_shift = {rem_reg, quo_reg[pds_pkg::NUMBER_WIDTH-1]};
    assign out_free  = !m_tvalid_reg || m_tready;

    // shared add/subtract unit: divider steps, shift-add products, final subtraction
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            pds_pkg::ST_DIV:
            begin
                alu_a   = pds_pkg::ALU_W'(rem_shift);
                alu_b   = pds_pkg::ALU_W'(d_reg);
                alu_sub = 1'b1;
            end
            pds_pkg::ST_MUL:
            begin
                alu_a = pds_pkg::ALU_W'(acc_reg);
                alu_b = y_reg[0] ? pds_pkg::ALU_W'(x_reg) : '0;
            end
            pds_pkg::ST_SUB:
            begin
                alu_a   = pds_pkg::ALU_W'(sigma_reg);
                alu_b   = pds_pkg::ALU_W'(n_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign borrow = alu_res[pds_pkg::ALU_W-1];
    assign diff   = alu_res[pds_pkg::SIG_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        mkind_next    = mkind_reg;
        n_next        = n_reg;
        rest_next     = rest_reg;
        sigma_next    = sigma_reg;
        term_next     = term_reg;
        d_next        = d_reg;
        dsq_next      = dsq_reg;
        dinc_next     = dinc_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next    = num_in;
                    rest_next = num_in;
                    term_next = pds_pkg::SIG_W'(1);
                    // zero and one: preset sigma to the number so the sum comes out zero
                    if (num_in <= pds_pkg::NUMBER_WIDTH'(1))
                    begin
                        sigma_next = pds_pkg::SIG_W'(num_in);
                        state_next = pds_pkg::ST_SUB;
                    end
                    else
                    begin
                        sigma_next = pds_pkg::SIG_W'(1);
                        state_next = pds_pkg::ST_TWO;
                    end
                end
            end

            pds_pkg::ST_TWO:
            begin
                // strip factors of two; term follows 1 + 2 + ... + 2^e by shifting in ones
                if (!rest_reg[0])
                begin
                    rest_next = rest_reg >> 1;
                    term_next = {term_reg[pds_pkg::SIG_W-2:0], 1'b1};
                end
                else
                begin
                    sigma_next = term_reg;
                    term_next  = pds_pkg::SIG_W'(1);
                    d_next     = pds_pkg::D_W'(3);
                    dsq_next   = pds_pkg::DSQ_W'(9);
                    dinc_next  = pds_pkg::DINC_W'(16);
                    state_next = pds_pkg::ST_CHECK;
                end
            end

            pds_pkg::ST_CHECK:
            begin
                if (dsq_reg > pds_pkg::DSQ_W'(rest_reg))
                begin
                    if (rest_reg > pds_pkg::NUMBER_WIDTH'(1))
                    begin
                        // leftover prime: sigma * (rest + 1) = sigma * rest + sigma
                        acc_next   = sigma_reg;
                        x_next     = sigma_reg;
                        y_next     = pds_pkg::SIG_W'(rest_reg);
                        mkind_next = pds_pkg::MUL_REST;
                        state_next = pds_pkg::ST_MUL;
                    end
                    else
                    begin
                        state_next = pds_pkg::ST_SUB;
                    end
                end
                else
                begin
                    quo_next   = rest_reg;
                    rem_next   = '0;
                    cnt_next   = pds_pkg::CNT_W'(pds_pkg::NUMBER_WIDTH);
                    state_next = pds_pkg::ST_DIV;
                end
            end

            pds_pkg::ST_DIV:
            begin
                rem_next = borrow ? rem_shift[pds_pkg::D_W-1:0] : diff[pds_pkg::D_W-1:0];
                quo_next = {quo_reg[pds_pkg::NUMBER_WIDTH-2:0], !borrow};
                cnt_next = cnt_reg - pds_pkg::CNT_W'(1);
                if (cnt_reg == pds_pkg::CNT_W'(1))
                begin
                    state_next = pds_pkg::ST_DIVEND;
                end
            end

            pds_pkg::ST_DIVEND:
            begin
                if (rem_reg == '0)
                begin
                    // divides: keep the quotient, term = term * d + 1
                    rest_next  = quo_reg;
                    acc_next   = pds_pkg::SIG_W'(1);
                    x_next     = term_reg;
                    y_next     = pds_pkg::SIG_W'(d_reg);
                    mkind_next = pds_pkg::MUL_TERM;
                    state_next = pds_pkg::ST_MUL;
                end
                else if (term_reg != pds_pkg::SIG_W'(1))
                begin
                    acc_next   = '0;
                    x_next     = sigma_reg;
                    y_next     = term_reg;
                    mkind_next = pds_pkg::MUL_SIGMA;
                    state_next = pds_pkg::ST_MUL;
                end
                else
                begin
                    state_next = pds_pkg::ST_NEXT;
                end
            end

            pds_pkg::ST_MUL:
            begin
                if (y_reg == '0)
                begin
                    case (mkind_reg)
                        pds_pkg::MUL_TERM:
                        begin
                            term_next  = acc_reg;
                            quo_next   = rest_reg;
                            rem_next   = '0;
                            cnt_next   = pds_pkg::CNT_W'(pds_pkg::NUMBER_WIDTH);
                            state_next = pds_pkg::ST_DIV;
                        end
                        pds_pkg::MUL_SIGMA:
                        begin
                            sigma_next = acc_reg;
                            term_next  = pds_pkg::SIG_W'(1);
                            state_next = pds_pkg::ST_NEXT;
                        end
                        default:
                        begin
                            sigma_next = acc_reg;
                            state_next = pds_pkg::ST_SUB;
                        end
                    endcase
                end
                else
                begin
                    acc_next = diff;
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                end
            end

            pds_pkg::ST_NEXT:
            begin
                // (d + 2)^2 = d^2 + 4d + 4; the step itself grows by 8
                d_next     = d_reg + pds_pkg::D_W'(2);
                dsq_next   = dsq_reg + pds_pkg::DSQ_W'(dinc_reg);
                dinc_next  = dinc_reg + pds_pkg::DINC_W'(8);
                state_next = pds_pkg::ST_CHECK;
            end

            pds_pkg::ST_SUB:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    sum_next      = (diff > pds_pkg::SIG_W'(pds_pkg::SUM_MAX)) ?
                                    pds_pkg::SUM_MAX : diff[pds_pkg::SUM_WIDTH-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = pds_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pds_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mkind_reg <= mkind_next;
        n_reg     <= n_next;
        rest_reg  <= rest_next;
        sigma_reg <= sigma_next;
        term_reg  <= term_next;
        d_reg     <= d_next;
        dsq_reg   <= dsq_next;
        dinc_reg  <= dinc_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sum_reg   <= sum_next;
    end

    assign s_tready = (state_reg == pds_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pds_pkg::OUT_TDATA_W'(sum_reg);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != pds_pkg::ST_IDLE))
        else $error("sequencer idle right after taking a number");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pds_pkg::ST_DIV) |-> (rem_reg < d_reg))
        else $error("partial remainder not below trial divisor");

    a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pds_pkg::ST_CHECK) |->
        (d_reg[0] && dsq_reg == pds_pkg::DSQ_W'(d_reg) * pds_pkg::DSQ_W'(d_reg)))
        else $error("trial divisor square out of step");

endmodule
